### hdl/three_wire_spi_master_macros.svh
// Assertion macros shared by the three-wire SPI master RTL
`ifndef THREE_WIRE_SPI_MASTER_MACROS_SVH
`define THREE_WIRE_SPI_MASTER_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset
`define TWS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tws: same-cycle check failed");

// Next-cycle implication, sampled on clock, quiet during reset
`define TWS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tws: next-cycle check failed");

`endif

### hdl/tws_pkg.sv
// Types and constants shared by the three-wire SPI master modules
`default_nettype none

package tws_pkg;

   localparam int ADDR_W     = 8;
   localparam int DATA_W     = 16;
   localparam int FRAME_W    = ADDR_W + DATA_W;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 1;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP       = 1'b1;

   // Register reset values
   localparam logic [CSR_W-1:0] HALF_PERIOD_RESET = 16'd5;
   localparam logic [CSR_W-1:0] SETUP_RESET       = 16'd8;

   // Engine phase
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_LEAD  = 3'd1,
      PH_SHIFT = 3'd2,
      PH_TRAIL = 3'd3
   } tws_phase_type;

   // One tick as it arrives
   typedef struct packed {
      logic              start_req;
      logic              operation;
      logic [ADDR_W-1:0] reg_address;
      logic [DATA_W-1:0] write_data;
      logic              sdio_in;
   } tws_req_type;

   // Pin levels and status after one tick
   typedef struct packed {
      logic              sclk;
      logic              sen;
      logic              sdio_out;
      logic              sdio_drive;
      logic              busy_res;
      logic              done_res;
      logic [DATA_W-1:0] read_data;
   } tws_rsp_type;

   // Decoded control part of a queued tick
   typedef struct packed {
      logic start_req;
      logic is_read;
      logic sdio_in;
   } tws_ctl_type;

endpackage

`default_nettype wire

### hdl/tws_queue.sv
// Small register FIFO used between the front, the engine and the result side
`default_nettype none

`include "three_wire_spi_master_macros.svh"

module tws_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_fire;
   logic             rd_fire;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_fire = wr_en && !full;
   assign rd_fire = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({wr_fire, rd_fire})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage, no reset needed
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `TWS_ASSERT_NEXT(a_q_fill, wr_fire && !rd_fire, count_ff == $past(count_ff) + CNT_W'(1))
   `TWS_ASSERT_NEXT(a_q_drain, rd_fire && !wr_fire, count_ff == $past(count_ff) - CNT_W'(1))
   `TWS_ASSERT_NEXT(a_q_pass, rd_fire && wr_fire, $stable(count_ff))

endmodule

`default_nettype wire

### hdl/tws_front.sv
// Front end: takes ticks, decodes them and queues them for the engine
`default_nettype none

module tws_front
   import tws_pkg::*;
#(
   parameter int DEPTH     = 2
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   input  wire tws_req_type                    req_data,
   output logic                                req_full,
   input  wire logic                           take,
   output logic                                cmd_valid,
   output tws_ctl_type                         cmd_ctl,
   output logic [FRAME_W-1:0]                  cmd_load
);

   localparam int TOTAL_BITS = FRAME_W;
   localparam int CTL_W      = $bits(tws_ctl_type);
   localparam int ENTRY_W    = CTL_W + TOTAL_BITS;

   tws_ctl_type           ctl_dec;
   logic [TOTAL_BITS-1:0] load_dec;
   logic [ENTRY_W-1:0]    head;
   logic                  q_empty;

   // Decode: reads shift the address followed by zeros
   always_comb begin
      ctl_dec.start_req = req_data.start_req;
      ctl_dec.is_read   = req_data.operation;
      ctl_dec.sdio_in   = req_data.sdio_in;
      load_dec = {req_data.reg_address,
                  req_data.operation ? {DATA_W{1'b0}} : req_data.write_data};
   end

   tws_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_push),
      .wr_data ({ctl_dec, load_dec}),
      .full    (req_full),
      .rd_en   (take),
      .rd_data (head),
      .empty   (q_empty)
   );

   assign cmd_valid = !q_empty;
   assign cmd_ctl   = tws_ctl_type'(head[ENTRY_W-1:TOTAL_BITS]);
   assign cmd_load  = head[TOTAL_BITS-1:0];

endmodule

`default_nettype wire

### hdl/tws_engine.sv
// Back end: SEN/SCLK/SDIO sequencer advancing one tick per step
`default_nettype none

`include "three_wire_spi_master_macros.svh"

module tws_engine
   import tws_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire tws_ctl_type                    cmd_ctl,
   input  wire logic [FRAME_W-1:0]             cmd_load,
   output tws_rsp_type                         result,
   input  wire logic                           csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]           csr_index,
   input  wire logic [CSR_W-1:0]               csr_write_data
);

   localparam int TOTAL_BITS = FRAME_W;
   localparam int BC_W       = $clog2(TOTAL_BITS + 1);

   logic [CSR_W-1:0]      half_ff, setup_ff;
   tws_phase_type         phase_ff, phase_in;
   logic [CSR_W-1:0]      tick_ff, tick_in;
   logic [BC_W-1:0]       bit_ff, bit_in;
   logic                  clk_high_ff, clk_high_in;
   logic [TOTAL_BITS-1:0] out_shift_ff, out_shift_in;
   logic [DATA_W-1:0]     in_shift_ff, in_shift_in;
   logic                  is_read_ff, is_read_in;

   logic [CSR_W-1:0]      limit;
   logic                  tick_done;
   logic [BC_W-1:0]       bit_inc;
   logic                  in_data_now;
   logic                  done;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff  <= HALF_PERIOD_RESET;
         setup_ff <= SETUP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HALF_PERIOD: half_ff  <= csr_write_data;
            CSR_SETUP:       setup_ff <= csr_write_data;
            default:         ;
         endcase
      end
   end

   // Phase length for the current phase; zero counts as one
   always_comb begin
      limit = (phase_ff == PH_SHIFT) ? half_ff : setup_ff;
      if (limit == '0) begin
         limit = CSR_W'(1);
      end
   end

   assign tick_done   = ({1'b0, tick_ff} + (CSR_W + 1)'(1)) >= {1'b0, limit};
   assign bit_inc     = bit_ff + BC_W'(1);
   assign in_data_now = is_read_ff && (bit_ff >= BC_W'(ADDR_W));

   // Next state
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      clk_high_in  = clk_high_ff;
      out_shift_in = out_shift_ff;
      in_shift_in  = in_shift_ff;
      is_read_in   = is_read_ff;
      done         = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (cmd_ctl.start_req) begin
               phase_in     = PH_LEAD;
               tick_in      = '0;
               bit_in       = '0;
               clk_high_in  = 1'b0;
               is_read_in   = cmd_ctl.is_read;
               out_shift_in = cmd_load;
            end
         end
         PH_LEAD: begin
            if (tick_done) begin
               phase_in    = PH_SHIFT;
               tick_in     = '0;
               clk_high_in = 1'b1;
               if (is_read_ff) begin
                  in_shift_in = '0;
               end
            end else begin
               tick_in = tick_ff + CSR_W'(1);
            end
         end
         PH_SHIFT: begin
            if (tick_done) begin
               tick_in = '0;
               if (clk_high_ff) begin
                  clk_high_in = 1'b0;
               end else begin
                  // end of low half: sample, advance one bit
                  if (in_data_now) begin
                     in_shift_in = DATA_W'({in_shift_ff, cmd_ctl.sdio_in});
                  end
                  out_shift_in = out_shift_ff << 1;
                  bit_in       = bit_inc;
                  if (bit_inc >= BC_W'(TOTAL_BITS)) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     clk_high_in = 1'b1;
                  end
               end
            end else begin
               tick_in = tick_ff + CSR_W'(1);
            end
         end
         default: begin
            // trailing wait; stray codes finish the same way
            if (tick_done) begin
               phase_in    = PH_IDLE;
               tick_in     = '0;
               bit_in      = '0;
               clk_high_in = 1'b0;
               done        = 1'b1;
            end else begin
               tick_in = tick_ff + CSR_W'(1);
            end
         end
      endcase
   end

   // Pin levels after this tick
   always_comb begin
      result            = '0;
      result.sen        = 1'b1;
      result.sdio_out   = 1'b1;
      result.sdio_drive = 1'b1;
      result.done_res   = done;
      case (phase_in)
         PH_IDLE: begin
            result.read_data = in_shift_in;
         end
         PH_LEAD: begin
            result.busy_res = 1'b1;
            result.sen      = 1'b0;
            result.sdio_out = 1'b0;
         end
         PH_SHIFT: begin
            result.busy_res = 1'b1;
            result.sen      = 1'b0;
            result.sclk     = clk_high_in;
            if (is_read_in && (bit_in >= BC_W'(ADDR_W))) begin
               result.sdio_drive = 1'b0;
            end else begin
               result.sdio_out = out_shift_in[TOTAL_BITS-1];
            end
         end
         default: begin
            result.busy_res = 1'b1;
            result.sen      = 1'b0;
            if (is_read_in) begin
               result.sdio_drive = 1'b0;
            end else begin
               result.sdio_out = 1'b0;
            end
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= '0;
         bit_ff      <= '0;
         clk_high_ff <= 1'b0;
         is_read_ff  <= 1'b0;
         out_shift_ff <= '0;
         in_shift_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_ff      <= bit_in;
         clk_high_ff <= clk_high_in;
         is_read_ff  <= is_read_in;
         out_shift_ff <= out_shift_in;
         in_shift_ff <= in_shift_in;
      end
   end

   `TWS_ASSERT_NEXT(a_start_to_lead, step && (phase_ff == PH_IDLE) && cmd_ctl.start_req, phase_ff == PH_LEAD)
   `TWS_ASSERT_NEXT(a_done_to_idle, step && result.done_res, (phase_ff == PH_IDLE) && (bit_ff == '0))
   `TWS_ASSERT_NEXT(a_hold_no_step, !step, $stable(phase_ff) && $stable(tick_ff) && $stable(bit_ff))
   `TWS_ASSERT_NOW(a_release_high, step && !result.sdio_drive, result.sdio_out && result.busy_res)

endmodule

`default_nettype wire

### hdl/three_wire_spi_master.sv
// Top level of the three-wire SPI master: front queue, engine, result queue
//
//   channel   ports                                   moves
//   req       req_push / req_full / req_data          one tick of pin time
//   rsp       rsp_pop / rsp_empty / rsp_data          pin levels after that tick
//   csr       csr_write_enable / csr_index / data     timing register write
//
// One tick is taken per clock cycle while req_full is low; the engine advances
// once per cycle when a queued tick and a free result slot are both present.
// A tick is registered in the front queue and its result in the result queue,
// so a result is visible only after both writes; a full result queue delays it.
// Reset is synchronous: queues empty, engine idle, SEN high, registers 5 and 8.
// A low rsp_pop stalls the engine once the result queue fills; req_full rises
// once the front queue fills behind it.
`default_nettype none

module three_wire_spi_master
   import tws_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire tws_req_type          req_data,
   output logic                      req_full,
   input  wire logic                 rsp_pop,
   output tws_rsp_type               rsp_data,
   output logic                      rsp_empty,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_write_data
);

   localparam int TOTAL_BITS = FRAME_W;

   logic                  cmd_valid;
   tws_ctl_type           cmd_ctl;
   logic [TOTAL_BITS-1:0] cmd_load;
   tws_rsp_type           result;
   logic                  out_full;
   logic                  step;

   // Engine moves when a tick waits and its result has somewhere to go
   assign step = cmd_valid && !out_full;

   tws_front #(
      .DEPTH     (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .take      (step),
      .cmd_valid (cmd_valid),
      .cmd_ctl   (cmd_ctl),
      .cmd_load  (cmd_load)
   );

   tws_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .cmd_ctl          (cmd_ctl),
      .cmd_load         (cmd_load),
      .result           (result),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Result queue decouples the engine from the consumer
   tws_queue #(
      .WIDTH ($bits(tws_rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (step),
      .wr_data (result),
      .full    (out_full),
      .rd_en   (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

endmodule

`default_nettype wire
